@@ rtl/rwc_pkg.sv @@
package rwc_pkg;

  // Bitmap depth in bytes, and the window_bytes value that saturates to it.
  localparam int MAX_WINDOW_BYTES = 32;
  localparam int ADDR_W = (MAX_WINDOW_BYTES > 1) ? $clog2(MAX_WINDOW_BYTES) : 1;

  localparam int SEQ_W = 32;
  localparam int WB_W = 6;
  localparam int FFC_W = 4;
  localparam int VERD_W = 3;
  // Wide enough for window sizes, spans and address compares.
  localparam int CMP_W = 10;

  localparam logic [WB_W-1:0] WB_CLAMP =
    WB_W'((MAX_WINDOW_BYTES > 63) ? 63 : MAX_WINDOW_BYTES);
  localparam logic [WB_W-1:0] WINDOW_RESET = WB_W'(16);
  localparam logic [SEQ_W-1:0] REKEY_LIMIT = 32'd1073741824;
  localparam logic [FFC_W-1:0] FFC_MAX = {FFC_W{1'b1}};

  // Remainder unit: the 32-bit byte number is consumed a nibble per cycle.
  localparam int MOD_BITS = 4;
  localparam int MOD_STEPS = SEQ_W / MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [VERD_W-1:0] V_IN_ORDER = 3'd0;
  localparam logic [VERD_W-1:0] V_LATE_OK = 3'd1;
  localparam logic [VERD_W-1:0] V_JUMP = 3'd2;
  localparam logic [VERD_W-1:0] V_FF_DROP = 3'd3;
  localparam logic [VERD_W-1:0] V_LATE_DROP = 3'd4;

endpackage

@@ rtl/rwc_if.sv @@
// Input channel: one sequence number per item.
interface rwc_in_if;
  logic valid;
  logic ready;
  logic [rwc_pkg::SEQ_W-1:0] seqno;

  modport source (output valid, output seqno, input ready);
  modport sink (input valid, input seqno, output ready);
endinterface

// Result channel: one verdict and the rekey flag per item.
interface rwc_out_if;
  logic valid;
  logic ready;
  logic [rwc_pkg::VERD_W-1:0] verdict;
  logic rekey_needed;

  modport source (output valid, output verdict, output rekey_needed, input ready);
  modport sink (input valid, input verdict, input rekey_needed, output ready);
endinterface

@@ rtl/replay_window_check_top.sv @@
// Channel   Direction  Handshake      Payload
// in_ch     in         valid/ready    seqno[31:0]
// out_ch    out        valid/ready    verdict[2:0], rekey_needed
// cfg_*     in         cfg_we strobe  cfg_wdata[5:0] = window_bytes
//
// One item at a time. Drops, jumps and window-disabled items are ruled on in
// classification alone. A late or ahead item runs the nibble-serial remainder
// unit and then a read-modify-write of the bitmap memory for each byte touched:
// one byte for a late item, up to W+1 bytes when an ahead gap spans the whole
// window. Reset is synchronous (rst_n low) and clears the bitmap at once
// through per-byte valid bits. A result waiting on out_ch does not stop the
// next item being taken, but that item holds its result until out_ch is free.
module replay_window_check_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [rwc_pkg::WB_W-1:0]  cfg_wdata,
  rwc_in_if.sink                    in_ch,
  rwc_out_if.source                 out_ch
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLASS = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_WR    = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int SW = rwc_pkg::SEQ_W;
  localparam int AW = rwc_pkg::ADDR_W;
  localparam int WW = rwc_pkg::WB_W;
  localparam int CW = rwc_pkg::CMP_W;

  // Architectural state.
  logic [WW-1:0]                window_r;
  logic [SW-1:0]                h_r, h_nxt;
  logic [rwc_pkg::FFC_W-1:0]    ffc_r, ffc_nxt;
  logic [rwc_pkg::MAX_WINDOW_BYTES-1:0] vld_r, vld_nxt;

  // Bitmap memory with a registered read port.
  logic [7:0]    mem [rwc_pkg::MAX_WINDOW_BYTES];
  logic [7:0]    rd_data_r;
  logic          rd_vld_r;
  logic          mem_we;
  logic [7:0]    mem_wdata;

  // Sequencer and per-item working registers.
  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [rwc_pkg::VERD_W-1:0] verd_r, verd_nxt;
  logic          late_r, late_nxt;
  logic          first_r, first_nxt;
  logic [2:0]    lo_r, lo_nxt;
  logic [WW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] p_r, p_nxt;
  logic [SW-1:0] q_r, q_nxt;
  logic [WW-1:0] rem_r, rem_nxt;
  logic [rwc_pkg::MOD_CNT_W-1:0] step_r, step_nxt;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [rwc_pkg::VERD_W-1:0] out_verd_r, out_verd_nxt;
  logic          out_rekey_r, out_rekey_nxt;

  // Classification of the held sequence number against the window.
  logic [WW-1:0] w_eff;
  logic [CW-1:0] span;
  logic [SW:0]   s33, h33, h_plus1, h_plus_span, s_plus_span;
  logic          w_zero, in_ord, far_fut, late, late_far, ff_drop;
  logic [SW-1:0] start_num;

  // Remainder step and byte update.
  logic [WW:0]   rem2;
  logic [WW-1:0] rem_step;
  logic [SW-1:0] q_step;
  logic [2:0]    lo_bit;
  logic [3:0]    hi_bit;
  logic          last_byte;
  logic [7:0]    cur_byte, mark_mask, clr_mask;

  assign w_eff = (window_r > rwc_pkg::WB_CLAMP) ? rwc_pkg::WB_CLAMP : window_r;
  assign span = CW'({w_eff, 3'b000});

  always_comb begin
    s33 = {1'b0, s_r};
    h33 = {1'b0, h_r};
    h_plus1 = h33 + (SW+1)'(1);
    h_plus_span = h33 + (SW+1)'(span);
    s_plus_span = s33 + (SW+1)'(span);
    w_zero = (w_eff == '0);
    in_ord = (s33 == h_plus1);
    far_fut = !in_ord && (s33 >= h_plus_span);
    late = !in_ord && !far_fut && (s33 <= h33);
    late_far = (s_plus_span <= h33);
    ff_drop = far_fut && (ffc_r < rwc_pkg::FFC_W'(w_eff >> 2));
    // A late item walks just its own byte; an ahead item starts after h.
    start_num = late ? s_r : h_plus1[SW-1:0];
  end

  // Restoring remainder, MOD_BITS quotient bits per cycle.
  always_comb begin
    rem_step = rem_r;
    q_step = q_r;
    rem2 = '0;
    for (int k = 0; k < rwc_pkg::MOD_BITS; k++) begin
      rem2 = {rem_step, q_step[SW-1]};
      q_step = {q_step[SW-2:0], 1'b0};
      if (rem2 >= {1'b0, w_eff}) begin
        rem2 = rem2 - {1'b0, w_eff};
      end
      rem_step = rem2[WW-1:0];
    end
  end

  // Byte update: mark the gap bits that fall in this byte, clear the bit of s.
  always_comb begin
    lo_bit = first_r ? lo_r : 3'd0;
    last_byte = (cnt_r == '0);
    hi_bit = last_byte ? {1'b0, s_r[2:0]} : 4'd8;
    cur_byte = rd_vld_r ? rd_data_r : 8'h00;
    for (int i = 0; i < 8; i++) begin
      mark_mask[i] = (3'(i) >= lo_bit) && (4'(i) < hi_bit);
    end
    clr_mask = last_byte ? (8'h01 << s_r[2:0]) : 8'h00;
    mem_wdata = (cur_byte | mark_mask) & ~clr_mask;
    mem_we = (state_r == ST_WR);
  end

  always_comb begin
    state_nxt = state_r;
    h_nxt = h_r;
    ffc_nxt = ffc_r;
    vld_nxt = vld_r;
    s_nxt = s_r;
    verd_nxt = verd_r;
    late_nxt = late_r;
    first_nxt = first_r;
    lo_nxt = lo_r;
    cnt_nxt = cnt_r;
    p_nxt = p_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    step_nxt = step_r;
    out_valid_nxt = out_valid_r;
    out_verd_nxt = out_verd_r;
    out_rekey_nxt = out_rekey_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          s_nxt = in_ch.seqno;
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        late_nxt = 1'b0;
        state_nxt = ST_DONE;
        if (w_zero) begin
          verd_nxt = rwc_pkg::V_IN_ORDER;
          if (s_r > h_r) begin
            h_nxt = s_r;
          end
        end else if (ff_drop) begin
          verd_nxt = rwc_pkg::V_FF_DROP;
          if (ffc_r != rwc_pkg::FFC_MAX) begin
            ffc_nxt = ffc_r + rwc_pkg::FFC_W'(1);
          end
        end else if (far_fut) begin
          // Window reset: the first W bytes read as zero from now on.
          verd_nxt = rwc_pkg::V_JUMP;
          ffc_nxt = '0;
          h_nxt = s_r;
          for (int i = 0; i < rwc_pkg::MAX_WINDOW_BYTES; i++) begin
            if (WW'(i) < w_eff) begin
              vld_nxt[i] = 1'b0;
            end
          end
        end else if (late && late_far) begin
          verd_nxt = rwc_pkg::V_LATE_DROP;
        end else begin
          if (late) begin
            late_nxt = 1'b1;
          end else begin
            verd_nxt = rwc_pkg::V_IN_ORDER;
            ffc_nxt = '0;
            h_nxt = s_r;
          end
          q_nxt = {3'b000, start_num[SW-1:3]};
          rem_nxt = '0;
          step_nxt = '0;
          lo_nxt = start_num[2:0];
          cnt_nxt = WW'(s_r[SW-1:3] - start_num[SW-1:3]);
          first_nxt = 1'b1;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        q_nxt = q_step;
        rem_nxt = rem_step;
        step_nxt = step_r + rwc_pkg::MOD_CNT_W'(1);
        if (step_r == rwc_pkg::MOD_CNT_W'(rwc_pkg::MOD_STEPS - 1)) begin
          p_nxt = AW'(rem_step);
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        vld_nxt[p_r] = 1'b1;
        if (late_r) begin
          if (cur_byte[s_r[2:0]]) begin
            verd_nxt = rwc_pkg::V_LATE_OK;
            ffc_nxt = '0;
          end else begin
            verd_nxt = rwc_pkg::V_LATE_DROP;
          end
        end
        if (last_byte) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - WW'(1);
          first_nxt = 1'b0;
          if (CW'(p_r) == CW'(w_eff) - CW'(1)) begin
            p_nxt = '0;
          end else begin
            p_nxt = p_r + AW'(1);
          end
          state_nxt = ST_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_verd_nxt = verd_r;
          out_rekey_nxt = (h_r > rwc_pkg::REKEY_LIMIT);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      window_r <= rwc_pkg::WINDOW_RESET;
      h_r <= '0;
      ffc_r <= '0;
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      h_r <= h_nxt;
      ffc_r <= ffc_nxt;
      vld_r <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    verd_r <= verd_nxt;
    late_r <= late_nxt;
    first_r <= first_nxt;
    lo_r <= lo_nxt;
    cnt_r <= cnt_nxt;
    p_r <= p_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    step_r <= step_nxt;
    out_verd_r <= out_verd_nxt;
    out_rekey_r <= out_rekey_nxt;
  end

  // Bitmap memory: one write port, one registered read port at the walk address.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[p_r] <= mem_wdata;
    end
    rd_data_r <= mem[p_r];
    rd_vld_r <= vld_r[p_r];
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.verdict = out_verd_r;
  assign out_ch.rekey_needed = out_rekey_r;

  a_accept_to_class: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_CLASS))
    else $error("accepted item did not enter classification");

  a_addr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR) |-> (CW'(p_r) < CW'(w_eff)))
    else $error("bitmap write outside the window");

  a_late_keeps_high: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLASS && s_r <= h_r) |=> $stable(h_r))
    else $error("highest sequence number moved on a late item");

  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (cnt_r <= w_eff))
    else $error("byte walk longer than the window");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (verd_r <= rwc_pkg::V_LATE_DROP))
    else $error("verdict code out of range");

endmodule

@@ tb/sv/replay_window_check_top_tb.sv @@
`timescale 1ns / 1ps

module replay_window_check_top_tb;

  // Run shape. The random part walks through PHASES window settings with
  // ITEMS_PER_PHASE sequence numbers each, so about 1700 items in all.
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int TOP_BURST = 30;
  // The receiver holds off this long when asked, which backs up the block.
  localparam int HOLD_CYCLES = 300;
  // The slowest item, a hold-off and sender gaps together stay far below
  // QUIET_LIMIT, so that many quiet cycles in a row mean the block is stuck.
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 20;

  // Window size per random phase. The phase marked by RANDOM_WIN_PHASE takes a
  // random size instead, and STEADY_PHASE runs without any idling at all.
  localparam logic [rwc_pkg::WB_W-1:0] PHASE_WIN [PHASES] =
    '{6'd16, 6'd4, 6'd1, 6'd32, 6'd63, 6'd0, 6'd8, 6'd2, 6'd3, 6'd33, 6'd0, 6'd12};
  localparam int RANDOM_WIN_PHASE = 10;
  localparam int STEADY_PHASE = 2;

  typedef struct packed {
    logic [rwc_pkg::VERD_W-1:0] verdict;
    logic                       rekey;
  } ruling_t;

  typedef enum logic {ROW_ITEM, ROW_WIN} row_kind_t;

  // One line of the directed script: either a sequence number, or a new window
  // size. Where typed is set, the expected ruling is given in the line itself.
  typedef struct {
    row_kind_t                  kind;
    logic [rwc_pkg::SEQ_W-1:0]  value;
    bit                         typed;
    logic [rwc_pkg::VERD_W-1:0] verdict;
    logic                       rekey;
  } row_t;

  // Opening script, from reset (window of 16 bytes, 128 numbers).
  localparam int OPENING_ROWS = 20;
  row_t opening [OPENING_ROWS] = '{
    '{ROW_ITEM, 32'd1,          1'b1, rwc_pkg::V_IN_ORDER,  1'b0}, // next after reset
    '{ROW_ITEM, 32'd1,          1'b1, rwc_pkg::V_LATE_DROP, 1'b0}, // replay of the top
    '{ROW_ITEM, 32'd5,          1'b0, rwc_pkg::V_IN_ORDER,  1'b0}, // ahead, leaves 2..4 open
    '{ROW_ITEM, 32'd3,          1'b0, rwc_pkg::V_IN_ORDER,  1'b0}, // fills a gap
    '{ROW_ITEM, 32'd3,          1'b1, rwc_pkg::V_LATE_DROP, 1'b0}, // the same gap again
    '{ROW_ITEM, 32'd133,        1'b1, rwc_pkg::V_FF_DROP,   1'b0}, // exactly one window ahead
    '{ROW_ITEM, 32'd200,        1'b0, rwc_pkg::V_IN_ORDER,  1'b0},
    '{ROW_ITEM, 32'h7FFF_FFFF,  1'b0, rwc_pkg::V_IN_ORDER,  1'b0},
    '{ROW_ITEM, 32'hFFFF_FFFF,  1'b0, rwc_pkg::V_IN_ORDER,  1'b0}, // drop count reaches W/4
    '{ROW_ITEM, 32'd1000,       1'b0, rwc_pkg::V_IN_ORDER,  1'b0}, // so this one jumps
    '{ROW_ITEM, 32'd2,          1'b0, rwc_pkg::V_IN_ORDER,  1'b0}, // far below the window
    '{ROW_ITEM, 32'd1127,       1'b0, rwc_pkg::V_IN_ORDER,  1'b0}, // widest ahead step
    '{ROW_ITEM, 32'd1001,       1'b0, rwc_pkg::V_IN_ORDER,  1'b0}, // oldest open number
    '{ROW_WIN,  32'd0,          1'b0, rwc_pkg::V_IN_ORDER,  1'b0}, // checking off
    '{ROW_ITEM, 32'd900,        1'b1, rwc_pkg::V_IN_ORDER,  1'b0},
    '{ROW_ITEM, 32'd1200,       1'b0, rwc_pkg::V_IN_ORDER,  1'b0},
    '{ROW_WIN,  32'd1,          1'b0, rwc_pkg::V_IN_ORDER,  1'b0}, // W/4 is zero: no far-ahead drops
    '{ROW_ITEM, 32'd1300,       1'b0, rwc_pkg::V_IN_ORDER,  1'b0},
    '{ROW_ITEM, 32'd1302,       1'b0, rwc_pkg::V_IN_ORDER,  1'b0},
    '{ROW_ITEM, 32'd1301,       1'b0, rwc_pkg::V_IN_ORDER,  1'b0}
  };

  // Closing script. The highest number only ever rises and the rekey flag
  // sticks, so the top of the range is only visited once the random part is
  // done.
  localparam int CLOSING_ROWS = 10;
  row_t closing [CLOSING_ROWS] = '{
    '{ROW_WIN,  32'd0,          1'b0, rwc_pkg::V_IN_ORDER,  1'b0},
    '{ROW_ITEM, 32'h4000_0000,  1'b1, rwc_pkg::V_IN_ORDER,  1'b0}, // at the rekey limit
    '{ROW_ITEM, 32'h4000_0001,  1'b1, rwc_pkg::V_IN_ORDER,  1'b1}, // just past it
    '{ROW_ITEM, 32'hFFFF_FFFE,  1'b1, rwc_pkg::V_IN_ORDER,  1'b1},
    '{ROW_WIN,  32'd16,         1'b0, rwc_pkg::V_IN_ORDER,  1'b0},
    '{ROW_ITEM, 32'hFFFF_FFFF,  1'b1, rwc_pkg::V_IN_ORDER,  1'b1}, // last number there is
    '{ROW_ITEM, 32'd0,          1'b1, rwc_pkg::V_LATE_DROP, 1'b1}, // no wrap to zero
    '{ROW_ITEM, 32'hFFFF_FFFF,  1'b1, rwc_pkg::V_LATE_DROP, 1'b1},
    '{ROW_WIN,  32'd63,         1'b0, rwc_pkg::V_IN_ORDER,  1'b0}, // saturates to 32 bytes
    '{ROW_ITEM, 32'hFFFF_FFF8,  1'b0, rwc_pkg::V_IN_ORDER,  1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [rwc_pkg::WB_W-1:0] cfg_wdata;

  rwc_in_if  seq_ch ();
  rwc_out_if ruling_ch ();

  replay_window_check_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (seq_ch),
    .out_ch    (ruling_ch)
  );

  always #2 clk = ~clk;

  // Shadow of the block's state, advanced at every accepted item.
  logic [rwc_pkg::SEQ_W-1:0]  top_seq;
  logic [rwc_pkg::FFC_W-1:0]  ff_drops;
  logic [7:0]                 gap_map [rwc_pkg::MAX_WINDOW_BYTES];
  logic [rwc_pkg::WB_W-1:0]   win_reg;

  ruling_t rulings_due [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  // Control of the sender and the receiver; lowered is the sender's own.
  bit steady = 1'b0;
  int unsigned holds_asked = 0;
  bit lowered = 1'b1;

  function automatic int unsigned effective_window();
    return (win_reg > rwc_pkg::MAX_WINDOW_BYTES) ? rwc_pkg::MAX_WINDOW_BYTES
                                                 : int'(win_reg);
  endfunction

  // Byte of the circular bitmap that holds number s, for a window of w bytes.
  function automatic int unsigned map_byte(longint unsigned s, int unsigned w);
    return int'((s / 8) % w);
  endfunction

  // Rule on one sequence number and update the shadow state. All sums are
  // taken at 64 bits so that the top of the range never wraps.
  function automatic ruling_t judge_seqno(logic [rwc_pkg::SEQ_W-1:0] seq);
    longint unsigned s;
    longint unsigned h;
    longint unsigned span;
    longint unsigned i;
    int unsigned w;
    logic [rwc_pkg::VERD_W-1:0] v;
    ruling_t r;
    s = seq;
    h = top_seq;
    w = effective_window();
    span = w * 8;
    v = rwc_pkg::V_IN_ORDER;
    if (w != 0) begin
      if (s != h + 1) begin
        if (s >= h + span) begin
          // Far ahead: a few drops are tolerated before the window restarts.
          if (ff_drops < (w >> 2)) begin
            if (ff_drops != rwc_pkg::FFC_MAX) ff_drops = ff_drops + 1'b1;
            v = rwc_pkg::V_FF_DROP;
          end else begin
            for (i = 0; i < w; i++) gap_map[i] = 8'h00;
            v = rwc_pkg::V_JUMP;
          end
        end else if (s <= h) begin
          if ((h >= span && s <= h - span) || !gap_map[map_byte(s, w)][3'(s)]) begin
            v = rwc_pkg::V_LATE_DROP;
          end else begin
            v = rwc_pkg::V_LATE_OK;
          end
        end else begin
          // Ahead inside the window: everything skipped becomes open.
          for (i = h + 1; i < s; i++) gap_map[map_byte(i, w)][3'(i)] = 1'b1;
        end
      end
      if (v != rwc_pkg::V_FF_DROP && v != rwc_pkg::V_LATE_DROP) begin
        ff_drops = '0;
        gap_map[map_byte(s, w)][3'(s)] = 1'b0;
      end
    end
    if (v != rwc_pkg::V_FF_DROP && v != rwc_pkg::V_LATE_DROP && s > h) top_seq = seq;
    r.verdict = v;
    r.rekey = (top_seq > rwc_pkg::REKEY_LIMIT);
    return r;
  endfunction

  // Choose the next sequence number from the shadow state. Most choices are
  // well formed (next, short gaps, gap fills) so the bitmap stays busy; the
  // rest are replays, stale numbers, far-future numbers and full-range noise.
  // Noise that would be accepted far ahead is folded back below the top, so
  // the highest number grows slowly and the top of the range stays for last.
  function automatic logic [rwc_pkg::SEQ_W-1:0] next_seqno();
    longint unsigned h;
    longint unsigned span;
    longint unsigned pick;
    longint unsigned off;
    longint unsigned cand;
    int unsigned w;
    int unsigned tries;
    int unsigned roll;
    h = top_seq;
    w = effective_window();
    span = w * 8;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      pick = h + 1;
    end else if (roll < 50) begin
      if (span > 2 && $urandom_range(0, 3) == 0) begin
        pick = h + 2 + $urandom_range(0, 32'(span - 3));
      end else begin
        pick = h + 2 + $urandom_range(0, 6);
      end
    end else if (roll < 70) begin
      pick = (h >= 2) ? h - $urandom_range(1, 2) : 0;
      for (tries = 0; tries < 12 && w != 0; tries++) begin
        off = $urandom_range(0, 32'(span - 1));
        if (off <= h) begin
          cand = h - off;
          if (gap_map[map_byte(cand, w)][3'(cand)]) pick = cand;
        end
      end
    end else if (roll < 80) begin
      off = $urandom_range(0, 32'(span + 8));
      pick = (h >= off) ? h - off : 0;
    end else if (roll < 88) begin
      pick = h + span + $urandom_range(0, 40);
    end else if (roll < 96) begin
      pick = $urandom;
      if (pick > h + 512 && (w == 0 || ff_drops >= (w >> 2))) pick = h >> 1;
    end else begin
      pick = (h > span) ? $urandom_range(0, 32'(h - span)) : 0;
    end
    return pick[rwc_pkg::SEQ_W-1:0];
  endfunction

  // Lower valid unless a gap already did it at this edge.
  task automatic pause_input();
    if (!lowered) begin
      seq_ch.valid <= 1'b0;
      lowered = 1'b1;
    end
  endtask

  // Offer one sequence number and wait for it to be taken. When it goes in,
  // its ruling joins the queue: the typed one if given, otherwise predicted.
  task automatic send_seqno(logic [rwc_pkg::SEQ_W-1:0] seq, bit typed, ruling_t want);
    ruling_t predicted;
    seq_ch.valid <= 1'b1;
    seq_ch.seqno <= seq;
    lowered = 1'b0;
    do @(posedge clk); while (!seq_ch.ready);
    predicted = judge_seqno(seq);
    rulings_due.push_back(typed ? want : predicted);
    if (!steady && $urandom_range(0, 99) < 36) begin
      seq_ch.valid <= 1'b0;
      lowered = 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // The window size is only changed once every ruling is back, so the block
  // is idle. The wait ends on a clock edge, so back-to-back writes never
  // give cfg_we two assignments in one step.
  task automatic set_window(logic [rwc_pkg::WB_W-1:0] bytes);
    pause_input();
    do @(posedge clk); while (rulings_due.size() != 0);
    cfg_we <= 1'b1;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_reg = bytes;
  endtask

  task automatic run_row(row_t row);
    ruling_t want;
    want.verdict = row.verdict;
    want.rekey = row.rekey;
    if (row.kind == ROW_WIN) begin
      set_window(row.value[rwc_pkg::WB_W-1:0]);
    end else begin
      send_seqno(row.value, row.typed, want);
    end
  endtask

  // Receiver: checks each ruling against the oldest one due, then decides
  // ready for the next cycle. A requested hold-off keeps ready low, long
  // enough for the block to fill and stall its input.
  int unsigned holds_granted = 0;
  int unsigned stall_left = 0;
  ruling_t due;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && ruling_ch.valid === 1'b1 && ruling_ch.ready === 1'b1) begin
      results_seen++;
      if (rulings_due.size() == 0) begin
        if (mismatches < 10) begin
          $display("ruling %0d arrived with none due: verdict %0d rekey %0d",
                   results_seen, ruling_ch.verdict, ruling_ch.rekey_needed);
        end
        mismatches++;
      end else begin
        due = rulings_due.pop_front();
        if (ruling_ch.verdict !== due.verdict || ruling_ch.rekey_needed !== due.rekey) begin
          if (mismatches < 10) begin
            $display("ruling %0d: expected verdict %0d rekey %0d, got verdict %0d rekey %0d",
                     results_seen, due.verdict, due.rekey,
                     ruling_ch.verdict, ruling_ch.rekey_needed);
          end
          mismatches++;
        end
      end
    end
    if (stall_left == 0 && holds_granted != holds_asked) begin
      holds_granted++;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left != 0) begin
      stall_left--;
      ruling_ch.ready <= 1'b0;
    end else begin
      ruling_ch.ready <= steady || ($urandom_range(0, 99) >= 36);
    end
  end

  // Watchdog: too long without any item moving on either channel.
  int unsigned quiet = 0;

  initial begin
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((seq_ch.valid === 1'b1 && seq_ch.ready === 1'b1) ||
          (ruling_ch.valid === 1'b1 && ruling_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[replay_window_check_top] ERROR");
    $finish;
  end

  // Main sequence: reset, the opening script, the random phases, then the
  // closing script with a short random burst at the top of the range.
  int ph;
  int n;

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    seq_ch.valid <= 1'b0;
    seq_ch.seqno <= '0;
    top_seq = '0;
    ff_drops = '0;
    foreach (gap_map[i]) gap_map[i] = 8'h00;
    win_reg = rwc_pkg::WINDOW_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening[r]) run_row(opening[r]);

    for (ph = 0; ph < PHASES; ph++) begin
      set_window((ph == RANDOM_WIN_PHASE) ? rwc_pkg::WB_W'($urandom_range(0, 63))
                                          : PHASE_WIN[ph]);
      steady = (ph == STEADY_PHASE);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Two long hold-offs, one with checking off and one with a wide window.
        if ((ph == 5 && n == 40) || (ph == 9 && n == 60)) holds_asked++;
        send_seqno(next_seqno(), 1'b0, '0);
      end
      steady = 1'b0;
    end

    foreach (closing[r]) run_row(closing[r]);
    repeat (TOP_BURST) send_seqno(next_seqno(), 1'b0, '0);

    pause_input();
    while (rulings_due.size() != 0) @(posedge clk);
    // Anything arriving now was never asked for and counts as a mismatch.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[replay_window_check_top] OK");
    end else begin
      $display("[replay_window_check_top] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rwc_pkg.sv
rtl/rwc_if.sv
rtl/replay_window_check_top.sv
tb/sv/replay_window_check_top_tb.sv
